// ----- rtl/bcel_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bcel_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_IS_LOGIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE = 1'd1;

  localparam logic [10:0] BATCH_MAX = 11'd1024;
  localparam logic [23:0] EPS_Q24 = 24'd17;
  localparam logic [23:0] ONE_M_EPS_Q24 = 24'hFFFFEF;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd49;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXP_MUL,
    CMD_EXP_SHIFT,
    CMD_DIV_SIG,
    CMD_SIG_TAKE,
    CMD_CLAMP,
    CMD_NORM,
    CMD_LN_MUL,
    CMD_LN_SUM,
    CMD_LOSS_A,
    CMD_LOSS_B,
    CMD_GRAD_PREP,
    CMD_GRAD_DEN,
    CMD_DIV_GRAD,
    CMD_GRAD_TAKE,
    CMD_UPDATE,
    CMD_DIV_MEAN,
    CMD_MEAN_TAKE,
    CMD_DIV_ACC,
    CMD_ACC_TAKE,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic div_done;
    logic logit;
    logic batch_done;
  } status_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0: v = 17'd65536;
      5'd1: v = 17'd62757;
      5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;
      5'd4: v = 17'd55109;
      5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;
      5'd7: v = 17'd48393;
      5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] ln_tab(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0: v = 16'd0;
      5'd1: v = 16'd3973;
      5'd2: v = 16'd7719;
      5'd3: v = 16'd11262;
      5'd4: v = 16'd14624;
      5'd5: v = 16'd17821;
      5'd6: v = 16'd20870;
      5'd7: v = 16'd23783;
      5'd8: v = 16'd26573;
      5'd9: v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41196;
      5'd15: v = 16'd43345;
      5'd16: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bcel_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bcel_div
  import bcel_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] q_sh;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_DEN_W:0]   rem_next;

  always_comb begin
    rem_sh = {rem, q_sh[DIV_NUM_W-1]};
    ge = rem_sh >= {1'b0, den_r};
    rem_next = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_sh <= num;
      rem <= '0;
      den_r <= den;
    end else if (busy) begin
      q_sh <= {q_sh[DIV_NUM_W-2:0], ge};
      rem <= rem_next[DIV_DEN_W-1:0];
    end
  end

  assign quot = q_sh;

endmodule
`default_nettype wire

// ----- rtl/bcel_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bcel_ctrl
  import bcel_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [18:0] {
    S_IDLE      = 19'b0000000000000000001,
    S_EXP_MUL   = 19'b0000000000000000010,
    S_EXP_SHIFT = 19'b0000000000000000100,
    S_SIG_DIV   = 19'b0000000000000001000,
    S_SIG_WAIT  = 19'b0000000000000010000,
    S_CLAMP     = 19'b0000000000000100000,
    S_NORM      = 19'b0000000000001000000,
    S_LN_SUM    = 19'b0000000000010000000,
    S_LOSS      = 19'b0000000000100000000,
    S_GRAD_PREP = 19'b0000000001000000000,
    S_GRAD_DEN  = 19'b0000000010000000000,
    S_GRAD_DIV  = 19'b0000000100000000000,
    S_GRAD_WAIT = 19'b0000001000000000000,
    S_UPDATE    = 19'b0000010000000000000,
    S_MEAN_DIV  = 19'b0000100000000000000,
    S_MEAN_WAIT = 19'b0001000000000000000,
    S_ACC_DIV   = 19'b0010000000000000000,
    S_ACC_WAIT  = 19'b0100000000000000000,
    S_OUT       = 19'b1000000000000000000
  } state_t;

  state_t state, state_next;
  logic   phase, phase_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd = CMD_NONE;
    in_ready = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = CMD_LOAD;
          state_next = status.logit ? S_EXP_MUL : S_CLAMP;
        end
      end
      S_EXP_MUL: begin
        cmd = CMD_EXP_MUL;
        state_next = S_EXP_SHIFT;
      end
      S_EXP_SHIFT: begin
        cmd = CMD_EXP_SHIFT;
        state_next = S_SIG_DIV;
      end
      S_SIG_DIV: begin
        cmd = CMD_DIV_SIG;
        state_next = S_SIG_WAIT;
      end
      S_SIG_WAIT: begin
        if (status.div_done) begin
          cmd = CMD_SIG_TAKE;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd = CMD_CLAMP;
        phase_next = 1'b0;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (status.norm_done) begin
          cmd = CMD_LN_MUL;
          state_next = S_LN_SUM;
        end else begin
          cmd = CMD_NORM;
        end
      end
      S_LN_SUM: begin
        cmd = CMD_LN_SUM;
        state_next = S_LOSS;
      end
      S_LOSS: begin
        if (!phase) begin
          cmd = CMD_LOSS_A;
          phase_next = 1'b1;
          state_next = S_NORM;
        end else begin
          cmd = CMD_LOSS_B;
          state_next = status.logit ? S_GRAD_DEN : S_GRAD_PREP;
        end
      end
      S_GRAD_PREP: begin
        cmd = CMD_GRAD_PREP;
        state_next = S_GRAD_DEN;
      end
      S_GRAD_DEN: begin
        cmd = CMD_GRAD_DEN;
        state_next = S_GRAD_DIV;
      end
      S_GRAD_DIV: begin
        cmd = CMD_DIV_GRAD;
        state_next = S_GRAD_WAIT;
      end
      S_GRAD_WAIT: begin
        if (status.div_done) begin
          cmd = CMD_GRAD_TAKE;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd = CMD_UPDATE;
        state_next = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        if (status.batch_done) begin
          cmd = CMD_DIV_MEAN;
          state_next = S_MEAN_WAIT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MEAN_WAIT: begin
        if (status.div_done) begin
          cmd = CMD_MEAN_TAKE;
          state_next = S_ACC_DIV;
        end
      end
      S_ACC_DIV: begin
        cmd = CMD_DIV_ACC;
        state_next = S_ACC_WAIT;
      end
      S_ACC_WAIT: begin
        if (status.div_done) begin
          cmd = CMD_ACC_TAKE;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd = CMD_OUT;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bcel_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bcel_dp
  import bcel_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic signed [23:0]    score,
  input  wire logic [16:0]           target,
  input  wire logic                  clear_metrics,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic signed [31:0]         gradient,
  output logic                       batch_done,
  output logic [23:0]                mean_loss,
  output logic [39:0]                loss_sum,
  output logic [31:0]                correct_count,
  output logic [31:0]                total_count,
  output logic [16:0]                accuracy
);

  logic        cfg_logit;
  logic [10:0] cfg_batch;
  logic [10:0] b_eff;

  logic signed [23:0] s_reg;
  logic [16:0] t_reg;
  logic [24:0] p;
  logic [24:0] y;
  logic [24:0] e;
  logic [23:0] pc;
  logic [24:0] nx;
  logic [4:0]  k;
  logic [31:0] lnprod;
  logic [20:0] lval;
  logic [37:0] prod1;
  logic [20:0] lossv;
  logic [22:0] d_r;
  logic [32:0] den_r;
  logic [24:0] mag;
  logic        neg;
  logic [31:0] grad;
  logic [9:0]  sample_index;
  logic [39:0] batch_acc;
  logic [39:0] running_loss;
  logic [31:0] running_correct;
  logic [31:0] running_total;
  logic        done_r;
  logic [23:0] mean_r;
  logic [16:0] acc_r;

  logic [23:0] abs_s;
  logic [40:0] exp_prod;
  logic [24:0] y_next;
  logic [8:0]  n;
  logic [16:0] pt_a, pt_b;
  logic [11:0] pdiff;
  logic [23:0] iprod;
  logic [16:0] v;
  logic [24:0] vs;
  logic [24:0] e_next;
  logic [25:0] d_sig;
  logic [24:0] p_load;
  logic [23:0] pc_next;
  logic [15:0] lt_a, lt_b;
  logic [11:0] ldiff;
  logic [15:0] lnm;
  logic [20:0] lval_next;
  logic [16:0] omt;
  logic [38:0] loss_sum_w;
  logic [48:0] dprod;
  logic [22:0] dfl;
  logic [24:0] t24;
  logic [24:0] gsrc;
  logic [40:0] ba_sum, rl_sum;
  logic [10:0] idx_inc;
  logic        idx_done;
  logic        correct_hit;
  logic        div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic        div_done;
  logic [DIV_NUM_W-1:0] quot;

  always_comb begin
    if (cfg_batch == 11'd0) begin
      b_eff = 11'd1;
    end else if (cfg_batch > BATCH_MAX) begin
      b_eff = BATCH_MAX;
    end else begin
      b_eff = cfg_batch;
    end
  end

  always_comb begin
    abs_s = s_reg[23] ? 24'(-s_reg) : 24'(s_reg);
    exp_prod = 41'(abs_s) * 41'(LOG2E_Q16);
    y_next = 25'((exp_prod + 41'd32768) >> 16);

    n = y[24:16];
    pt_a = pow2_tab({1'b0, y[15:12]});
    pt_b = pow2_tab({1'b0, y[15:12]} + 5'd1);
    pdiff = 12'(pt_a - pt_b);
    iprod = 24'(pdiff) * 24'(y[11:0]);
    v = pt_a - 17'(iprod >> 12);
    vs = {v, 8'd0};
    e_next = (n >= 9'd26) ? '0 : (vs >> n[4:0]);

    d_sig = 26'(1 << 24) + 26'(e);

    if (score[23]) begin
      p_load = '0;
    end else if (score[22:0] > 23'd65536) begin
      p_load = 25'(1 << 24);
    end else begin
      p_load = {score[16:0], 8'd0};
    end

    if (p < 25'(EPS_Q24)) begin
      pc_next = EPS_Q24;
    end else if (p > 25'(ONE_M_EPS_Q24)) begin
      pc_next = ONE_M_EPS_Q24;
    end else begin
      pc_next = p[23:0];
    end

    lt_a = ln_tab({1'b0, nx[23:20]});
    lt_b = ln_tab({1'b0, nx[23:20]} + 5'd1);
    ldiff = 12'(lt_b - lt_a);
    lnm = lt_a + 16'(lnprod >> 20);
    lval_next = 21'(k * LN2_Q16) - 21'(lnm);

    omt = 17'd65536 - t_reg;
    loss_sum_w = 39'(prod1) + 39'(omt) * 39'(lval) + 39'd32768;

    dprod = 49'(pc) * 49'(25'(1 << 24) - 25'(pc));
    dfl = (d_r < 23'(EPS_Q24)) ? 23'(EPS_Q24) : d_r;

    t24 = {t_reg, 8'd0};
    gsrc = cfg_logit ? p : 25'(pc);

    ba_sum = 41'(batch_acc) + 41'(lossv);
    rl_sum = 41'(running_loss) + 41'(lossv);
    idx_inc = 11'(sample_index) + 11'd1;
    idx_done = idx_inc >= b_eff;
    correct_hit = (pc[23] == (t_reg >= 17'd32768));
  end

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    case (cmd)
      CMD_DIV_SIG: begin
        div_start = 1'b1;
        div_den = 33'(d_sig);
        if (s_reg[23]) begin
          div_num = (49'(e) << 24) + 49'(d_sig >> 1);
        end else begin
          div_num = (49'(1) << 48) + 49'(d_sig >> 1);
        end
      end
      CMD_DIV_GRAD: begin
        div_start = 1'b1;
        div_den = den_r;
        div_num = (cfg_logit ? 49'(mag) : (49'(mag) << 16)) + 49'(den_r >> 1);
      end
      CMD_DIV_MEAN: begin
        div_start = 1'b1;
        div_den = 33'(b_eff);
        div_num = 49'(batch_acc) + 49'(b_eff >> 1);
      end
      CMD_DIV_ACC: begin
        div_start = 1'b1;
        div_den = 33'(running_total);
        div_num = (49'(running_correct) << 16) + 49'(running_total >> 1);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bcel_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_logit <= 1'b1;
      cfg_batch <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_IS_LOGIT: cfg_logit <= cfg_data[0];
        REG_BATCH_SIZE: cfg_batch <= cfg_data;
        default: cfg_logit <= cfg_logit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      batch_acc <= '0;
      running_loss <= '0;
      running_correct <= '0;
      running_total <= '0;
      done_r <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          if (clear_metrics) begin
            sample_index <= '0;
            batch_acc <= '0;
            running_loss <= '0;
            running_correct <= '0;
            running_total <= '0;
          end
        end
        CMD_UPDATE: begin
          batch_acc <= ba_sum[40] ? '1 : ba_sum[39:0];
          running_loss <= rl_sum[40] ? '1 : rl_sum[39:0];
          if (correct_hit && running_correct != '1) begin
            running_correct <= running_correct + 32'd1;
          end
          if (running_total != '1) begin
            running_total <= running_total + 32'd1;
          end
          sample_index <= idx_done ? '0 : idx_inc[9:0];
          done_r <= idx_done;
        end
        CMD_MEAN_TAKE: begin
          batch_acc <= '0;
        end
        default: begin
          done_r <= done_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        s_reg <= score;
        t_reg <= (target > 17'd65536) ? 17'd65536 : target;
        p <= p_load;
      end
      CMD_EXP_MUL: y <= y_next;
      CMD_EXP_SHIFT: e <= e_next;
      CMD_SIG_TAKE: p <= quot[24:0];
      CMD_CLAMP: begin
        pc <= pc_next;
        nx <= 25'(pc_next);
        k <= '0;
      end
      CMD_NORM: begin
        if (nx[24:21] == 4'd0) begin
          nx <= nx << 4;
          k <= k + 5'd4;
        end else begin
          nx <= nx << 1;
          k <= k + 5'd1;
        end
      end
      CMD_LN_MUL: lnprod <= 32'(ldiff) * 32'(nx[19:0]);
      CMD_LN_SUM: lval <= lval_next;
      CMD_LOSS_A: begin
        prod1 <= 38'(t_reg) * 38'(lval);
        nx <= 25'(1 << 24) - 25'(pc);
        k <= '0;
      end
      CMD_LOSS_B: lossv <= 21'(loss_sum_w >> 16);
      CMD_GRAD_PREP: d_r <= 23'(dprod >> 24);
      CMD_GRAD_DEN: begin
        den_r <= cfg_logit ? (33'(b_eff) << 8) : 33'(dfl) * 33'(b_eff);
        neg <= gsrc < t24;
        mag <= (gsrc < t24) ? t24 - gsrc : gsrc - t24;
      end
      CMD_GRAD_TAKE: begin
        if (neg) begin
          grad <= (quot > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(-quot[31:0]);
        end else begin
          grad <= (quot > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
        end
      end
      CMD_UPDATE: begin
        mean_r <= '0;
        acc_r <= '0;
      end
      CMD_MEAN_TAKE: mean_r <= (quot > 49'hFF_FFFF) ? 24'hFF_FFFF : quot[23:0];
      CMD_ACC_TAKE: acc_r <= (quot > 49'd65536) ? 17'd65536 : quot[16:0];
      CMD_OUT: begin
        gradient <= grad;
        batch_done <= done_r;
        mean_loss <= mean_r;
        loss_sum <= running_loss;
        correct_count <= running_correct;
        total_count <= running_total;
        accuracy <= acc_r;
      end
      default: begin
        s_reg <= s_reg;
      end
    endcase
  end

  assign status.norm_done = nx[24];
  assign status.div_done = div_done;
  assign status.logit = cfg_logit;
  assign status.batch_done = done_r;

endmodule
`default_nettype wire

// ----- rtl/bce_loss_metrics.sv -----
// A sample takes longer in logit mode than in probability mode (sigmoid division),
// and longer again when it ends a batch (mean and accuracy divisions).
// Throughput: one sample at a time; the next is taken once the result is registered.
// Timing is set by the shared radix-2 divider (49 steps per division), used
// one to four times per sample, and by the one-bit/four-bit log normaliser.
// Reset (rst, synchronous): metrics and batch progress cleared, input_is_logit = 1,
// batch_size = 1, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module bce_loss_metrics
  import bcel_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [23:0]    score,
  input  wire logic [16:0]           target,
  input  wire logic                  clear_metrics,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [31:0]         gradient,
  output logic                       batch_done,
  output logic [23:0]                mean_loss,
  output logic [39:0]                loss_sum,
  output logic [31:0]                correct_count,
  output logic [31:0]                total_count,
  output logic [16:0]                accuracy
);

  cmd_t    cmd;
  status_t status;

  bcel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bcel_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .score         (score),
    .target        (target),
    .clear_metrics (clear_metrics),
    .cmd           (cmd),
    .status        (status),
    .gradient      (gradient),
    .batch_done    (batch_done),
    .mean_loss     (mean_loss),
    .loss_sum      (loss_sum),
    .correct_count (correct_count),
    .total_count   (total_count),
    .accuracy      (accuracy)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second sample taken while one is in flight");

  a_mid_batch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !batch_done) |-> (mean_loss == 24'd0 && accuracy == 17'd0))
    else $error("mean or accuracy set before end of batch");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accuracy <= 17'd65536))
    else $error("accuracy above one");
`endif

endmodule
`default_nettype wire

// ----- bench/bce_loss_metrics_checker.sv -----
`timescale 1ns / 1ps
module bce_loss_metrics_checker
  import bcel_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [23:0]         score,
  input  logic [16:0]                target,
  input  logic                       clear_metrics,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [31:0]         gradient,
  input  logic                       batch_done,
  input  logic [23:0]                mean_loss,
  input  logic [39:0]                loss_sum,
  input  logic [31:0]                correct_count,
  input  logic [31:0]                total_count,
  input  logic [16:0]                accuracy,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [31:0] grad;
    logic        done;
    logic [23:0] mean;
    logic [39:0] lsum;
    logic [31:0] correct;
    logic [31:0] total;
    logic [16:0] acc;
  } metrics_t;

  localparam longint unsigned ONE24 = 64'd16777216;
  localparam longint unsigned EPS24 = 64'd17;
  localparam longint unsigned MAX40 = 64'hFF_FFFF_FFFF;

  metrics_t expected_q[$];
  logic        logit_mode;
  logic [10:0] bsize;
  logic [9:0]  idx_in_batch;
  longint unsigned batch_acc, run_loss;
  logic [31:0] run_correct, run_total;

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint unsigned exp2_neg(longint unsigned y);
    longint unsigned n, v, a, b;
    int i;
    longint unsigned fr;
    n = y >> 16;
    i = (y >> 12) & 15;
    fr = y & 12'hFFF;
    if (n >= 26) return 0;
    a = pow2_tab(5'(i));
    b = pow2_tab(5'(i + 1));
    v = a - (((a - b) * fr) >> 12);
    return (v << 8) >> n;
  endfunction

  function automatic longint unsigned nlog(longint unsigned x);
    int b;
    longint unsigned f, fr, lm, a, c;
    int i;
    b = 24;
    if (x == 0) x = 1;
    while (b > 0 && ((x >> b) & 1) == 0) b--;
    f = (x << (24 - b)) & 24'hFFFFFF;
    i = f >> 20;
    fr = f & 20'hFFFFF;
    a = ln_tab(5'(i));
    c = ln_tab(5'(i + 1));
    lm = a + (((c - a) * fr) >> 20);
    return longint'(24 - b) * 45426 - lm;
  endfunction

  function automatic logic [31:0] sat_quot(bit neg, longint unsigned mag,
                                           longint unsigned den);
    longint unsigned q;
    q = rdiv(mag, den);
    if (neg) return (q > 64'd2147483648) ? 32'h8000_0000 : 32'(-longint'(q));
    return (q > 64'd2147483647) ? 32'h7FFF_FFFF : 32'(q);
  endfunction

  function automatic metrics_t predict_sample(logic signed [23:0] sc, logic [16:0] tg,
                                              logic clr);
    metrics_t r;
    longint s, b;
    longint unsigned t, p, pc, lv, mag, e, d, t24;
    bit neg;
    s = sc;
    t = (tg > 17'd65536) ? 65536 : tg;
    b = (bsize == 0) ? 1 : (bsize > 1024 ? 1024 : bsize);
    if (clr) begin
      idx_in_batch = 0; batch_acc = 0; run_loss = 0; run_correct = 0; run_total = 0;
    end
    if (logit_mode) begin
      e = exp2_neg(((s < 0 ? -s : s) * 94548 + 32768) >> 16);
      d = ONE24 + e;
      p = (s >= 0) ? rdiv(ONE24 * ONE24, d) : rdiv(e * ONE24, d);
    end else begin
      p = (s < 0) ? 0 : (s > 65536 ? ONE24 : longint'(s) << 8);
    end
    pc = p;
    if (pc < EPS24) pc = EPS24;
    if (pc > ONE24 - EPS24) pc = ONE24 - EPS24;
    lv = (t * nlog(pc) + (65536 - t) * nlog(ONE24 - pc) + 32768) >> 16;
    t24 = t << 8;
    if (logit_mode) begin
      neg = p < t24;
      mag = neg ? t24 - p : p - t24;
      r.grad = sat_quot(neg, mag, 256 * b);
    end else begin
      d = (pc * (ONE24 - pc)) >> 24;
      if (d < EPS24) d = EPS24;
      neg = pc < t24;
      mag = neg ? t24 - pc : pc - t24;
      r.grad = sat_quot(neg, mag << 16, d * b);
    end
    batch_acc += lv;
    if (batch_acc > MAX40) batch_acc = MAX40;
    run_loss += lv;
    if (run_loss > MAX40) run_loss = MAX40;
    if ((pc >= (ONE24 >> 1)) == (t >= 32768) && run_correct != 32'hFFFF_FFFF)
      run_correct++;
    if (run_total != 32'hFFFF_FFFF) run_total++;
    idx_in_batch++;
    r.done = (longint'(idx_in_batch) >= b) || (idx_in_batch == 0);
    r.mean = 0;
    r.acc = 0;
    if (r.done) begin
      e = rdiv(batch_acc, b);
      r.mean = (e > 64'hFFFFFF) ? 24'hFFFFFF : 24'(e);
      e = (run_total != 0) ? rdiv(longint'(run_correct) << 16, run_total) : 0;
      r.acc = (e > 65536) ? 17'd65536 : 17'(e);
      idx_in_batch = 0;
      batch_acc = 0;
    end
    r.lsum = 40'(run_loss);
    r.correct = run_correct;
    r.total = run_total;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    metrics_t want, got;
    if (rst) begin
      logit_mode <= 1'b1;
      bsize <= 11'd1;
      idx_in_batch = 0; batch_acc = 0; run_loss = 0; run_correct = 0; run_total = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INPUT_IS_LOGIT) logit_mode <= cfg_data[0];
        else if (cfg_index == REG_BATCH_SIZE) bsize <= cfg_data;
      end
      if (in_valid && in_ready)
        expected_q.push_back(predict_sample(score, target, clear_metrics));
      if (out_valid && out_ready) begin
        got = '{gradient, batch_done, mean_loss, loss_sum, correct_count, total_count,
                accuracy};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch exp g=%0d d=%0d m=%0d l=%0d c=%0d t=%0d a=%0d | ",
                       $signed(want.grad), want.done, want.mean, want.lsum,
                       want.correct, want.total, want.acc,
                       "got g=%0d d=%0d m=%0d l=%0d c=%0d t=%0d a=%0d",
                       $signed(got.grad), got.done, got.mean, got.lsum,
                       got.correct, got.total, got.acc);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/bce_loss_metrics_tb.sv -----
`timescale 1ns / 1ps
module bce_loss_metrics_tb;
  import bcel_pkg::*;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [23:0] score;
  logic [16:0] target;
  logic clear_metrics;
  logic signed [31:0] gradient;
  logic batch_done;
  logic [23:0] mean_loss;
  logic [39:0] loss_sum;
  logic [31:0] correct_count, total_count;
  logic [16:0] accuracy;
  int fail_count, pending;
  bit calm, hold_off;
  int idle_cycles;

  bce_loss_metrics dut (.*);
  bce_loss_metrics_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [23:0] sc, logic [16:0] tg, logic clr);
    while (!calm && $urandom_range(99) < 21) @(posedge clk);
    in_valid <= 1'b1; score <= sc; target <= tg; clear_metrics <= clr;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int n, bit logit);
    logic signed [23:0] sc;
    logic [16:0] tg;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: sc = $urandom;
        1: sc = logit ? 24'($signed($urandom_range(1200000)) - 600000)
                      : 24'($urandom_range(65536));
        2: sc = logit ? 24'($signed($urandom_range(4000)) - 2000)
                      : 24'($urandom_range(300));
        default: sc = logit ? 24'($signed($urandom_range(100000)) - 50000)
                            : 24'(65536 - $urandom_range(300));
      endcase
      case ($urandom_range(4))
        0: tg = 0;
        1: tg = 65536;
        2: tg = $urandom;
        default: tg = $urandom_range(65536);
      endcase
      send_sample(sc, tg, $urandom_range(40) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; score = '0; target = '0; clear_metrics = 1'b0;
    calm = 1'b0; hold_off = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed, logit mode, batch of 1
    send_sample(24'sh7FFFFF, 17'd65536, 1'b0);
    send_sample(-24'sh800000, 17'd0, 1'b0);
    send_sample(24'sd0, 17'd32768, 1'b0);
    send_sample(24'sd65536, 17'h1FFFF, 1'b0);
    send_sample(-24'sd65536, 17'd0, 1'b1);
    drain();
    write_reg(REG_INPUT_IS_LOGIT, 11'd0);
    write_reg(REG_BATCH_SIZE, 11'd3);
    send_sample(-24'sd5, 17'd65536, 1'b0);
    send_sample(24'sd70000, 17'd0, 1'b0);
    send_sample(24'sd0, 17'd0, 1'b0);
    send_sample(24'sd65536, 17'd65536, 1'b0);
    send_sample(24'sd32768, 17'd32767, 1'b0);
    send_sample(24'sd1, 17'd65535, 1'b0);
    send_sample(24'sd65535, 17'd0, 1'b1);
    drain();
    write_reg(REG_BATCH_SIZE, 11'd0);
    send_sample(24'sd100, 17'd65536, 1'b0);
    send_sample(24'sd30000, 17'd32768, 1'b0);
    drain();
    write_reg(REG_BATCH_SIZE, 11'h7FF);
    send_sample(24'sd40000, 17'd65536, 1'b0);
    drain();
    write_reg(REG_BATCH_SIZE, 11'd2);
    send_sample(24'sd40000, 17'd65536, 1'b0);
    send_sample(24'sd20000, 17'd0, 1'b0);
    send_sample(24'sd50000, 17'd1000, 1'b0);
    drain();
    write_reg(REG_BATCH_SIZE, 11'd1);
    send_sample(24'sd50000, 17'd1000, 1'b0);
    drain();
    // back-pressure while the sender keeps offering
    hold_off = 1'b1;
    fork
      send_random(4, 1'b0);
      begin repeat (600) @(posedge clk); hold_off = 1'b0; end
    join
    drain();
    write_reg(REG_INPUT_IS_LOGIT, 11'd1);
    write_reg(REG_BATCH_SIZE, 11'd5);
    send_random(137, 1'b1);
    drain();
    write_reg(REG_INPUT_IS_LOGIT, 11'd0);
    write_reg(REG_BATCH_SIZE, 11'd7);
    calm = 1'b1;
    send_random(80, 1'b0);
    calm = 1'b0;
    drain();
    write_reg(REG_BATCH_SIZE, 11'd1024);
    send_random(60, 1'b0);
    drain();
    write_reg(REG_INPUT_IS_LOGIT, 11'd1);
    write_reg(REG_BATCH_SIZE, 11'd1);
    send_random(100, 1'b1);
    drain();
    write_reg(REG_BATCH_SIZE, 11'd4);
    send_random(50, 1'b1);
    drain();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
